FILE: rtl/hpi_pkg.sv
package hpi_pkg;

    // Field widths of the configuration registers.
    localparam int LEVELS_W    = 5;
    localparam int DIMS_W      = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // Largest number of levels; larger register values saturate here.
    localparam int LEVELS_MAX = 30;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_LEVELS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIMS   = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } hpi_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                step;
        logic                publish;
        logic [DIMS_W-1:0]   dims;
        logic                overflow;
    } hpi_cmd_t;

endpackage

FILE: rtl/hpi_ctrl.sv
module hpi_ctrl
    import hpi_pkg::*;
#(
    parameter int MAX_DIMS   = 10,
    parameter int INDEX_BITS = 60
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hpi_cmd_t               cmd
);

    hpi_state_t          state_reg, state_next;
    logic [LEVELS_W-1:0] level_cnt_reg, level_cnt_next;
    logic [LEVELS_W-1:0] levels_reg;
    logic [DIMS_W-1:0]   dims_reg;
    logic                out_valid_reg, out_valid_next;
    logic [LEVELS_W-1:0] levels_eff;
    logic [DIMS_W-1:0]   dims_eff;
    logic [LEVELS_W+DIMS_W-1:0] bit_count;

    // Out-of-range register values saturate into the legal range.
    always_comb
    begin
        if (levels_reg == '0)
            levels_eff = LEVELS_W'(1);
        else if (levels_reg > LEVELS_W'(LEVELS_MAX))
            levels_eff = LEVELS_W'(LEVELS_MAX);
        else
            levels_eff = levels_reg;

        if (dims_reg == '0)
            dims_eff = DIMS_W'(1);
        else if (dims_reg > DIMS_W'(MAX_DIMS))
            dims_eff = DIMS_W'(MAX_DIMS);
        else
            dims_eff = dims_reg;
    end

    assign bit_count = (LEVELS_W+DIMS_W)'(levels_eff) * (LEVELS_W+DIMS_W)'(dims_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_W'(10);
            dims_reg   <= DIMS_W'(2);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LEVELS)
                levels_reg <= cfg_data[LEVELS_W-1:0];
            else if (cfg_index == REG_DIMS)
                dims_reg <= cfg_data[DIMS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_cnt_reg <= level_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        level_cnt_next = level_cnt_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.publish    = 1'b0;
        cmd.dims       = dims_eff;
        cmd.overflow   = ({1'b0, bit_count} > (LEVELS_W+DIMS_W+1)'(INDEX_BITS));

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    level_cnt_next = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step       = 1'b1;
                level_cnt_next = level_cnt_reg + LEVELS_W'(1);
                if (level_cnt_reg == levels_eff - LEVELS_W'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/hpi_datapath.sv
module hpi_datapath
    import hpi_pkg::*;
#(
    parameter int MAX_DIMS   = 10,
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 60
) (
    input  logic                           clk,
    input  hpi_cmd_t                       cmd,
    input  logic [MAX_DIMS*COORD_BITS-1:0] in_coords,
    output logic [INDEX_BITS-1:0]          curve_index,
    output logic                           index_overflow
);

    localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [COORD_BITS-1:0] QUARTER = COORD_BITS'(1) << (COORD_BITS - 2);

    logic [COORD_BITS-1:0] w_reg  [MAX_DIMS];
    logic [COORD_BITS-1:0] w_next [MAX_DIMS];
    logic [MAX_DIMS-1:0]   iw_reg, iw_next;      // 1 marks a negative direction
    logic [IW-1:0]         it_reg, it_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [INDEX_BITS-1:0] curve_index_reg;
    logic                  index_overflow_reg;

    logic [MAX_DIMS-1:0]   ub, us, kb, vb, vs, rev;
    logic [MAX_DIMS-1:0]   digit;
    logic [IW-1:0]         last_neg, last_pos, ex, nm1;
    logic                  d_zero, d_all;
    logic [INDEX_BITS+MAX_DIMS-1:0] shifted;

    assign nm1 = IW'(cmd.dims - DIMS_W'(1));

    always_comb
    begin
        // Sign of every coordinate and the move toward the sub-cube centre.
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            ub[i] = w_reg[i][COORD_BITS-1] ^ iw_reg[i];
            if (w_reg[i][COORD_BITS-1])
                w_next[i] = (w_reg[i] + QUARTER) << 1;
            else
                w_next[i] = (w_reg[i] - QUARTER) << 1;
        end

        us         = ub;
        us[0]      = ub[it_reg];
        us[it_reg] = ub[0];

        // Alternating sign chain that yields the Gray-code digit bits.
        kb[0] = us[0];
        for (int i = 1; i < MAX_DIMS; i++)
            kb[i] = ~(kb[i-1] ^ us[i]);

        last_neg = '0;
        last_pos = '0;
        rev      = '0;
        d_zero   = 1'b1;
        d_all    = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (i < int'(cmd.dims))
            begin
                rev[MAX_DIMS-1-i] = ~kb[i];
                if (kb[i])
                begin
                    last_neg = IW'(i);
                    d_all    = 1'b0;
                end
                else
                begin
                    last_pos = IW'(i);
                    d_zero   = 1'b0;
                end
            end
        end
        digit = rev >> (DIMS_W'(MAX_DIMS) - cmd.dims);

        // Direction vector and exit axis of the chosen sub-cube.
        vb = us;
        if (d_zero)
            ex = nm1;
        else
        begin
            vb[nm1] = ~vb[nm1];
            if (d_all)
                ex = nm1;
            else if (last_neg == nm1)
            begin
                vb[last_pos] = ~vb[last_pos];
                ex = last_pos;
            end
            else
                ex = last_neg;
        end

        vs         = vb;
        vs[0]      = vb[it_reg];
        vs[it_reg] = vb[0];

        iw_next = ~(iw_reg ^ vs);

        if (ex == '0)
            it_next = it_reg;
        else if (ex == it_reg)
            it_next = '0;
        else
            it_next = ex;

        shifted  = ({{MAX_DIMS{1'b0}}, idx_reg} << cmd.dims)
                 | {{INDEX_BITS{1'b0}}, digit};
        idx_next = shifted[INDEX_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
                w_reg[i] <= in_coords[i*COORD_BITS +: COORD_BITS];
            iw_reg  <= '0;
            it_reg  <= '0;
            idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
                w_reg[i] <= w_next[i];
            iw_reg  <= iw_next;
            it_reg  <= it_next;
            idx_reg <= idx_next;
        end

        if (cmd.publish)
        begin
            curve_index_reg    <= idx_reg;
            index_overflow_reg <= cmd.overflow;
        end
    end

    assign curve_index    = curve_index_reg;
    assign index_overflow = index_overflow_reg;

endmodule

FILE: rtl/hilbert_point_to_index.sv
// Items are taken only in IDLE; the controller then runs RUN once per level, and DRAIN
// publishes the result and sets the registered m_tvalid, waiting while an unread result
// is held. The shared level unit does one curve level per cycle, all dimensions at once.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, asynchronous) empties the block and sets levels to 10, dims to 2.
module hilbert_point_to_index
    import hpi_pkg::*;
#(
    parameter int MAX_DIMS   = 10,
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 60
) (
    input  logic                   clk,
    input  logic                   rst_n,

    // Configuration write port: index 0 is levels, index 1 is dims.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // Input items: one point of the cube.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata fields from bit 0 up: coord_0, coord_1, ... coord_(MAX_DIMS-1),
    // each COORD_BITS wide, then zero fill to a whole byte.
    input  logic [((MAX_DIMS*COORD_BITS+7)/8)*8-1:0] s_tdata,

    // Result items: one curve index per point.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata fields from bit 0 up: curve_index, then zero fill to a whole byte.
    output logic [((INDEX_BITS+7)/8)*8-1:0] m_tdata,
    // m_tuser fields from bit 0 up: index_overflow.
    output logic                   m_tuser
);

    localparam int OUT_W = ((INDEX_BITS + 7) / 8) * 8;

    hpi_cmd_t              cmd;
    logic [INDEX_BITS-1:0] curve_index;
    logic                  index_overflow;

    // The controller owns the configuration registers, the level counter and
    // the output valid flag; it runs IDLE -> RUN (one level a cycle) -> DRAIN.
    hpi_ctrl #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // The datapath keeps the working coordinates, the direction signs, the
    // entry axis and the growing index, and holds the published result.
    hpi_datapath #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .in_coords      (s_tdata[MAX_DIMS*COORD_BITS-1:0]),
        .curve_index    (curve_index),
        .index_overflow (index_overflow)
    );

    assign m_tdata = OUT_W'(curve_index);
    assign m_tuser = index_overflow;

endmodule
